// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on posedge, reset-qualified or not.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every clock, disabled while reset is held
`define SDFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked every clock, also during reset
`define SDFB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/sdfb_pkg.sv
// ----------------------------------------------------------------------------
// sdfb_pkg
// Shared types, constants and helpers of the SMS-DELIVER frame builder.
// ----------------------------------------------------------------------------
package sdfb_pkg;

  localparam int unsigned FRAME_MAX             = 250;
  localparam int unsigned MAX_ORIGINATOR_DIGITS = 16;

  localparam logic [7:0] CP_DATA_TYPE = 8'h89;
  localparam logic [7:0] CP_DATA_MTI  = 8'h01;
  localparam logic [7:0] RP_DATA_MTI  = 8'h01;
  localparam logic [7:0] TON_INTL     = 8'h91;
  localparam logic [7:0] TON_UNKNOWN  = 8'h81;
  localparam logic [7:0] FO_DELIVER   = 8'h04;
  localparam logic [7:0] FO_UDHI      = 8'h40;
  localparam logic [7:0] DCS_DEFAULT  = 8'h04;
  localparam logic [7:0] UDH_LEN      = 8'h06;
  localparam logic [7:0] IEI_PORT16   = 8'h05;
  localparam logic [7:0] IE_PORT_LEN  = 8'h04;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [3:0] NIB_PAD      = 4'hF;
  localparam logic [7:0] UDH_TOTAL    = 8'd7;

  typedef enum logic [2:0] {
    REG_ORIG_DIGITS = 3'd0,
    REG_ORIG_COUNT  = 3'd1,
    REG_CODING      = 3'd2,
    REG_DEST_PORT   = 3'd3,
    REG_ORIG_PORT   = 3'd4,
    REG_PAYLOAD_LEN = 3'd5
  } cfg_reg_t;

  // values derived from the configuration registers
  typedef struct packed {
    logic [7:0][7:0] oa;
    logic [3:0]      oal;
    logic [4:0]      nd;
    logic [7:0]      rp;
    logic [7:0]      tp;
    logic [7:0]      udl;
    logic [7:0]      fo;
    logic [7:0]      otype;
    logic [7:0]      dcs;
    logic [7:0]      len;
    logic [15:0]     dport;
    logic [15:0]     oport;
    logic [5:0]      hdr_last;
    logic            drop;
  } cfg_info_t;

  // nibble-swapped decimal: units in high nibble, tens mod 10 in low nibble
  function automatic logic [7:0] swap_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [3:0]  tens_m;
    logic [7:0]  tens10;
    prod   = 15'(v) * 15'd205;
    tens   = prod[14:11];
    tens10 = 8'(tens) * 8'd10;
    units  = 4'({1'b0, v} - tens10);
    tens_m = (tens >= 4'd10) ? 4'(tens - 4'd10) : tens;
    return {units, tens_m};
  endfunction

endpackage

// File: hdl/sdfb_in_if.sv
// ----------------------------------------------------------------------------
// sdfb_in_if
// Input channel: one payload byte plus timestamp fields per item.
// ----------------------------------------------------------------------------
interface sdfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [6:0] stamp_year;
  logic [3:0] stamp_month;
  logic [4:0] stamp_day;
  logic [4:0] stamp_hour;
  logic [5:0] stamp_minute;
  logic [5:0] stamp_second;

  modport source (
    output valid, payload_byte, stamp_year, stamp_month, stamp_day,
           stamp_hour, stamp_minute, stamp_second,
    input  ready
  );
  modport sink (
    input  valid, payload_byte, stamp_year, stamp_month, stamp_day,
           stamp_hour, stamp_minute, stamp_second,
    output ready
  );
endinterface

// File: hdl/sdfb_out_if.sv
// ----------------------------------------------------------------------------
// sdfb_out_if
// Result channel: one frame byte with its flags per item.
// ----------------------------------------------------------------------------
interface sdfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       run_last;
  logic       frame_start;
  logic       frame_end;
  logic       dropped;

  modport source (
    output valid, frame_byte, run_last, frame_start, frame_end, dropped,
    input  ready
  );
  modport sink (
    input  valid, frame_byte, run_last, frame_start, frame_end, dropped,
    output ready
  );
endinterface

// File: hdl/sdfb_cfg_if.sv
// ----------------------------------------------------------------------------
// sdfb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sdfb_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  addr;
  logic [63:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// File: hdl/sms_deliver_frame_builder.sv
// ----------------------------------------------------------------------------
// sms_deliver_frame_builder
// Builds CP-DATA / RP-DATA / SMS-DELIVER frames from payload bytes.
//
//   channel  dir  handshake    carries
//   in_ch    in   valid/ready  payload byte, timestamp fields
//   out_ch   out  valid/ready  frame byte, run/frame flags, drop flag
//   cfg_ch   in   valid/ready  register index, 64-bit write data
//
// Later payload bytes pass back to back through the hold and result
// registers while the output is not stalled. The first byte of a message
// follows 22 + 2*ceil(digits/2) header bytes (digits taken as 1 to 16, +7
// with port header) from the header sequencer.
// Bytes of an oversized frame pass without output and yield one flagged item
// on the last byte. Reset is synchronous; no clearing pass. Output stalls
// back-pressure the input through the hold register; cfg_ch is always ready.
// ----------------------------------------------------------------------------
module sms_deliver_frame_builder
  import sdfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sdfb_in_if.sink    in_ch,
  sdfb_out_if.source out_ch,
  sdfb_cfg_if.sink   cfg_ch
);

  cfg_info_t info;

  sdfb_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (cfg_ch.valid),
    .wr_ready (cfg_ch.ready),
    .wr_addr  (cfg_ch.addr),
    .wr_data  (cfg_ch.data),
    .info     (info)
  );

  sdfb_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .info         (info),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_byte      (in_ch.payload_byte),
    .in_year      (in_ch.stamp_year),
    .in_month     (in_ch.stamp_month),
    .in_day       (in_ch.stamp_day),
    .in_hour      (in_ch.stamp_hour),
    .in_minute    (in_ch.stamp_minute),
    .in_second    (in_ch.stamp_second),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_byte     (out_ch.frame_byte),
    .out_run_last (out_ch.run_last),
    .out_start    (out_ch.frame_start),
    .out_end      (out_ch.frame_end),
    .out_dropped  (out_ch.dropped)
  );

endmodule

// File: hdl/sdfb_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdfb_cfg_regs
// Configuration registers and the header values derived from them.
// ----------------------------------------------------------------------------
module sdfb_cfg_regs
  import sdfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  logic [2:0]  wr_addr,
  input  logic [63:0] wr_data,
  output cfg_info_t   info
);

  logic [63:0] digits_r;
  logic [4:0]  count_r;
  logic [7:0]  coding_r;
  logic [15:0] dport_r;
  logic [15:0] oport_r;
  logic [7:0]  plen_r;

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      digits_r <= '0;
      count_r  <= '0;
      coding_r <= DCS_DEFAULT;
      dport_r  <= '0;
      oport_r  <= '0;
      plen_r   <= 8'd1;
    end else if (wr_valid) begin
      unique case (wr_addr)
        REG_ORIG_DIGITS: digits_r <= wr_data;
        REG_ORIG_COUNT:  count_r  <= wr_data[4:0];
        REG_CODING:      coding_r <= wr_data[7:0];
        REG_DEST_PORT:   dport_r  <= wr_data[15:0];
        REG_ORIG_PORT:   oport_r  <= wr_data[15:0];
        REG_PAYLOAD_LEN: plen_r   <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  logic [4:0]  n_sat;
  logic [4:0]  nd;
  logic [63:0] dig;
  logic [3:0]  oal;
  logic        pt;
  logic [7:0]  udh;
  logic [7:0]  len;
  logic [8:0]  tp9;
  logic [9:0]  rp9;
  logic [9:0]  total;
  logic [5:0]  nd_sum;

  always_comb begin
    n_sat  = (count_r > 5'(MAX_ORIGINATOR_DIGITS)) ? 5'(MAX_ORIGINATOR_DIGITS) : count_r;
    nd     = (n_sat == 5'd0) ? 5'd1 : n_sat;
    dig    = (n_sat == 5'd0) ? 64'd0 : digits_r;
    nd_sum = {1'b0, nd} + 6'd1;
    oal    = nd_sum[4:1];
    pt     = (dport_r != 16'd0) || (oport_r != 16'd0);
    udh    = pt ? UDH_TOTAL : 8'd0;
    len    = (plen_r == 8'd0) ? 8'd1 : plen_r;
    tp9    = 9'd13 + 9'(oal) + 9'(udh) + 9'(len);
    rp9    = 10'd6 + 10'(oal) + 10'(tp9);
    total  = 10'd3 + rp9;

    for (int i = 0; i < 8; i++) begin
      info.oa[i][3:0] = dig[8*i +: 4];
      info.oa[i][7:4] = (6'(2*i+1) < {1'b0, nd}) ? dig[8*i+4 +: 4] : NIB_PAD;
    end
    info.oal      = oal;
    info.nd       = nd;
    info.rp       = rp9[7:0];
    info.tp       = tp9[7:0];
    info.udl      = 8'(udh + len);
    info.fo       = pt ? (FO_DELIVER | FO_UDHI) : FO_DELIVER;
    info.otype    = (nd <= 5'd3) ? TON_UNKNOWN : TON_INTL;
    info.dcs      = (coding_r != 8'd0) ? coding_r : DCS_DEFAULT;
    info.len      = len;
    info.dport    = dport_r;
    info.oport    = oport_r;
    info.hdr_last = 6'd21 + 6'({oal, 1'b0}) + 6'(udh);
    info.drop     = total > 10'(FRAME_MAX);
  end

endmodule

// File: hdl/sdfb_hdr_byte.sv
// ----------------------------------------------------------------------------
// sdfb_hdr_byte
// Selects the header byte at a given position of the CP/RP/TPDU header.
// ----------------------------------------------------------------------------
module sdfb_hdr_byte
  import sdfb_pkg::*;
(
  input  logic [5:0]      idx,
  input  cfg_info_t       info,
  input  logic [7:0]      mref,
  input  logic [5:0][7:0] stamp,
  output logic [7:0]      hdr_byte
);

  logic [5:0] oal6;
  logic [5:0] a;
  logic [5:0] j;
  logic [5:0] b;
  logic [5:0] m;

  assign oal6 = {2'b00, info.oal};
  assign a    = idx - 6'd7;
  assign j    = a - oal6;
  assign b    = j - 6'd5;
  assign m    = b - oal6;

  always_comb begin
    hdr_byte = BYTE_ZERO;
    if (idx < 6'd7) begin
      case (idx[2:0])
        3'd0:    hdr_byte = CP_DATA_TYPE;
        3'd1:    hdr_byte = CP_DATA_MTI;
        3'd2:    hdr_byte = info.rp;
        3'd3:    hdr_byte = RP_DATA_MTI;
        3'd4:    hdr_byte = mref;
        3'd5:    hdr_byte = 8'(oal6) + 8'd1;
        3'd6:    hdr_byte = TON_INTL;
        default: hdr_byte = BYTE_ZERO;
      endcase
    end else if (a < oal6) begin
      hdr_byte = info.oa[a[2:0]];
    end else if (j < 6'd5) begin
      case (j[2:0])
        3'd1:    hdr_byte = info.tp;
        3'd2:    hdr_byte = info.fo;
        3'd3:    hdr_byte = {3'b000, info.nd};
        3'd4:    hdr_byte = info.otype;
        default: hdr_byte = BYTE_ZERO;
      endcase
    end else if (b < oal6) begin
      hdr_byte = info.oa[b[2:0]];
    end else begin
      case (m[4:0])
        5'd1:    hdr_byte = info.dcs;
        5'd2:    hdr_byte = stamp[0];
        5'd3:    hdr_byte = stamp[1];
        5'd4:    hdr_byte = stamp[2];
        5'd5:    hdr_byte = stamp[3];
        5'd6:    hdr_byte = stamp[4];
        5'd7:    hdr_byte = stamp[5];
        5'd9:    hdr_byte = info.udl;
        5'd10:   hdr_byte = UDH_LEN;
        5'd11:   hdr_byte = IEI_PORT16;
        5'd12:   hdr_byte = IE_PORT_LEN;
        5'd13:   hdr_byte = info.dport[15:8];
        5'd14:   hdr_byte = info.dport[7:0];
        5'd15:   hdr_byte = info.oport[15:8];
        5'd16:   hdr_byte = info.oport[7:0];
        default: hdr_byte = BYTE_ZERO;
      endcase
    end
  end

endmodule

// File: hdl/sdfb_seq.sv
// ----------------------------------------------------------------------------
// sdfb_seq
// Item hold register, header sequencer and result register.
// ----------------------------------------------------------------------------
module sdfb_seq
  import sdfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_info_t  info,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [6:0] in_year,
  input  logic [3:0] in_month,
  input  logic [4:0] in_day,
  input  logic [4:0] in_hour,
  input  logic [5:0] in_minute,
  input  logic [5:0] in_second,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_start,
  output logic       out_end,
  output logic       out_dropped
);

  // message state
  logic [7:0] pos_r;
  logic [7:0] mref_r;

  // hold register
  logic            hv_r;
  logic            hdr_r;
  logic [5:0]      idx_r;
  logic            last_r;
  logic            drop_r;
  logic [7:0]      byte_r;
  logic [7:0]      href_r;
  logic [5:0][7:0] stamp_r;

  // result register
  logic       ov_r;
  logic [7:0] obyte_r;
  logic       orl_r;
  logic       ostart_r;
  logic       oend_r;
  logic       odrop_r;

  logic            accept;
  logic            out_load;
  logic            emit;
  logic            consume;
  logic            first;
  logic            last;
  logic [7:0]      mref_inc;
  logic [7:0]      mref_nxt;
  logic [8:0]      pos_inc;
  logic [5:0][7:0] stamp_nxt;
  logic [7:0]      hdr_byte;
  logic [7:0]      ebyte;
  logic            erl;
  logic            estart;
  logic            eend;
  logic            edrop;

  sdfb_hdr_byte u_hdr (
    .idx      (idx_r),
    .info     (info),
    .mref     (href_r),
    .stamp    (stamp_r),
    .hdr_byte (hdr_byte)
  );

  always_comb begin
    out_load = !ov_r || out_ready;
    emit     = hv_r && out_load && !(drop_r && !last_r);
    consume  = hv_r && (drop_r ? (!last_r || out_load) : (out_load && !hdr_r));
    in_ready = !hv_r || consume;
    accept   = in_valid && in_ready;

    first    = (pos_r == 8'd0);
    pos_inc  = {1'b0, pos_r} + 9'd1;
    last     = pos_inc >= {1'b0, info.len};
    mref_inc = mref_r + 8'd1;
    mref_nxt = (mref_inc == 8'd0) ? 8'd1 : mref_inc;

    stamp_nxt[0] = swap_bcd(in_year);
    stamp_nxt[1] = swap_bcd(7'(in_month));
    stamp_nxt[2] = swap_bcd(7'(in_day));
    stamp_nxt[3] = swap_bcd(7'(in_hour));
    stamp_nxt[4] = swap_bcd(7'(in_minute));
    stamp_nxt[5] = swap_bcd(7'(in_second));

    if (drop_r) begin
      ebyte  = BYTE_ZERO;
      erl    = 1'b1;
      estart = 1'b0;
      eend   = 1'b1;
      edrop  = 1'b1;
    end else if (hdr_r) begin
      ebyte  = hdr_byte;
      erl    = 1'b0;
      estart = (idx_r == 6'd0);
      eend   = 1'b0;
      edrop  = 1'b0;
    end else begin
      ebyte  = byte_r;
      erl    = 1'b1;
      estart = 1'b0;
      eend   = last_r;
      edrop  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      mref_r <= '0;
      hv_r   <= 1'b0;
      hdr_r  <= 1'b0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (accept) begin
        pos_r  <= last ? 8'd0 : pos_inc[7:0];
        if (first) begin
          mref_r <= mref_nxt;
        end
        hv_r   <= 1'b1;
        hdr_r  <= first && !info.drop;
        idx_r  <= '0;
      end else begin
        if (consume) begin
          hv_r <= 1'b0;
        end
        if (emit && hdr_r && !drop_r) begin
          if (idx_r == info.hdr_last) begin
            hdr_r <= 1'b0;
          end
          idx_r <= idx_r + 6'd1;
        end
      end
      if (emit) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r  <= last;
      drop_r  <= info.drop;
      byte_r  <= in_byte;
      href_r  <= first ? mref_nxt : mref_r;
      stamp_r <= stamp_nxt;
    end
    if (emit) begin
      obyte_r  <= ebyte;
      orl_r    <= erl;
      ostart_r <= estart;
      oend_r   <= eend;
      odrop_r  <= edrop;
    end
  end

  assign out_valid    = ov_r;
  assign out_byte     = obyte_r;
  assign out_run_last = orl_r;
  assign out_start    = ostart_r;
  assign out_end      = oend_r;
  assign out_dropped  = odrop_r;

endmodule

// File: hdl/sdfb_checker.sv
// ----------------------------------------------------------------------------
// sdfb_checker
// Port-level checks on the result channel of the frame builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sdfb_checker
  import sdfb_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] frame_byte,
  input logic       run_last,
  input logic       frame_start,
  input logic       frame_end,
  input logic       dropped
);

  `SDFB_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(frame_byte) && $stable(run_last), "stalled item changed")
  `SDFB_ASSERT(a_drop_form, clk, rst_n, out_valid && dropped |-> frame_end && run_last && !frame_start && frame_byte == BYTE_ZERO, "bad drop item")
  `SDFB_ASSERT(a_start_form, clk, rst_n, out_valid && frame_start |-> frame_byte == CP_DATA_TYPE && !run_last && !frame_end, "bad frame start")
  `SDFB_ASSERT(a_end_last, clk, rst_n, out_valid && frame_end |-> run_last, "frame end not last of run")

endmodule

bind sms_deliver_frame_builder sdfb_checker u_sdfb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .frame_byte  (out_ch.frame_byte),
  .run_last    (out_ch.run_last),
  .frame_start (out_ch.frame_start),
  .frame_end   (out_ch.frame_end),
  .dropped     (out_ch.dropped)
);
